FILE: rtl/core/nearest_actor_box_pick_assert.svh
// assertion macros shared by the pick block
`ifndef NEAREST_ACTOR_BOX_PICK_ASSERT_SVH
`define NEAREST_ACTOR_BOX_PICK_ASSERT_SVH

// same-cycle implication
`define NABP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NABP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/nabp_pkg.sv
// types, constants and helper functions of the actor box pick block
package nabp_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W     = 10;
   localparam int FRAC_W    = 17;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int NUM_W     = 50;
   localparam int DEN_W     = 33;
   localparam int T_W       = 19;
   localparam int QBITS     = 17;

   localparam logic [FRAC_W-1:0] FRAC_ONE      = 17'd65536;
   localparam logic [63:0]       SCALE_EPS_Q32 = 64'd4294;
   localparam logic signed [31:0] SCALE_UNIT   = 32'sd65536;

   // box factors in q16.16
   localparam logic signed [MUL_W-1:0] K_BOX_XZ  = 33'sd32768;
   localparam logic signed [MUL_W-1:0] K_BOX_H   = 33'sd65536;
   localparam logic signed [MUL_W-1:0] K_CAP_XZ  = 33'sd22938;
   localparam logic signed [MUL_W-1:0] K_TALL_H  = 33'sd117965;
   localparam logic signed [MUL_W-1:0] K_RECT_X  = 33'sd29491;
   localparam logic signed [MUL_W-1:0] K_RECT_Z  = 33'sd16384;

   typedef enum logic [1:0] {
      MESH_BOX     = 2'd0,
      MESH_CAPSULE = 2'd1,
      MESH_RECT    = 2'd2
   } mesh_kind_type;

   typedef enum logic [2:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_START_Z = 3'd2,
      CSR_END_X   = 3'd3,
      CSR_END_Y   = 3'd4,
      CSR_END_Z   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic signed [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic signed [T_W-1:0] quo;
   } div_rsp_type;

   // round to nearest, ties up, then drop 16 fraction bits
   function automatic logic signed [49:0] round_q16(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + 66'sd32768;
      return s[PROD_W-1:16];
   endfunction

   // clamp to signed 32-bit
   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      logic signed [31:0] r;
      if (x > 36'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -36'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/nabp_mul.sv
// shared signed multiplier with registered product
module nabp_mul (
   input  logic                                   clock,
   input  logic signed [nabp_pkg::MUL_W-1:0]      a,
   input  logic signed [nabp_pkg::MUL_W-1:0]      b,
   output logic signed [nabp_pkg::PROD_W-1:0]     p
);
   import nabp_pkg::*;

   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] p_in;

   // full product of the selected operands
   assign p_in = a * b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;
endmodule

FILE: rtl/core/nabp_div.sv
// iterative floor divider, quotient clamped near the unit interval
module nabp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  nabp_pkg::div_req_type  req,
   output nabp_pkg::div_rsp_type  rsp
);
   import nabp_pkg::*;

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_DONE
   } dstate_type;

   dstate_type        state_ff;
   logic [4:0]        cnt_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [NUM_W-1:0]  dsh_ff;
   logic [QBITS:0]    q_ff;
   logic              same_ff;

   logic [NUM_W-1:0]  un_in;
   logic [DEN_W-1:0]  ud_in;
   logic [NUM_W-1:0]  ud_top;
   logic              big_in;
   logic              can_start;
   logic              fits;
   logic [NUM_W-1:0]  rem_sub;
   logic signed [T_W-1:0] qs;

   // magnitudes of the operands
   assign un_in  = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
   assign ud_in  = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
   assign ud_top = NUM_W'({ud_in, 17'b0});
   assign big_in = (un_in >= ud_top);
   assign can_start = req.start && (state_ff != D_RUN);

   // one restoring step
   assign fits    = (rem_ff >= dsh_ff);
   assign rem_sub = rem_ff - dsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            D_IDLE, D_DONE: begin
               if (can_start) begin
                  same_ff <= (req.num[NUM_W-1] == req.den[DEN_W-1]);
                  rem_ff  <= un_in;
                  dsh_ff  <= NUM_W'({ud_in, 16'b0});
                  cnt_ff  <= 5'(QBITS - 1);
                  if (big_in) begin
                     q_ff     <= 18'd131072;
                     state_ff <= D_DONE;
                  end else begin
                     q_ff     <= '0;
                     state_ff <= D_RUN;
                  end
               end else begin
                  state_ff <= D_IDLE;
               end
            end
            D_RUN: begin
               q_ff   <= {q_ff[QBITS-1:0], fits};
               rem_ff <= fits ? rem_sub : rem_ff;
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == '0) begin
                  state_ff <= D_DONE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   // floor correction for opposite signs
   assign qs = T_W'(q_ff);
   assign rsp.done = (state_ff == D_DONE);
   assign rsp.quo  = same_ff ? qs : (-qs - T_W'(rem_ff != '0));
endmodule

FILE: rtl/core/nearest_actor_box_pick.sv
// nearest actor box pick: sequencer around one multiplier and one divider
// a named item within capacity runs through at most these steps: 4 square steps, a
// unit check, 4 half-size steps, a box step, per axis one step and two divisions,
// then best, next and accept steps; an unnamed or overflow item takes the accept and
// next steps; a last item adds the hit point steps and the result register
// reset (synchronous, high) clears the segment registers and the list
module nearest_actor_box_pick (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [2:0]    csr_addr,
   input  logic [31:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // position_x, position_y, position_z, scale_x, scale_y, scale_z
   input  logic [191:0]  req_tdata,
   // mesh_kind, named
   input  logic [2:0]    req_tuser,
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // hit_index, hit_fraction, point_x/y/z, box_min_x/y/z, box_max_x/y/z, pad
   output logic [319:0]  rsp_tdata,
   // hit
   output logic          rsp_tuser
);
   import nabp_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_UNIT, S_HALF, S_BOX, S_AXIS, S_DIV_LO, S_DIV_HI,
      S_BEST, S_NEXT, S_POINT, S_EMIT
   } state_type;

   state_type                 state_ff;
   logic signed [31:0]        start_ff [3];
   logic signed [31:0]        end_ff   [3];
   logic signed [31:0]        pos_ff   [3];
   logic signed [31:0]        sc_ff    [3];
   logic [1:0]                kind_ff;
   logic                      last_ff;
   logic [1:0]                cnt_ff;
   logic [1:0]                axis_ff;
   logic [63:0]               ssum_ff;
   logic signed [33:0]        half_ff  [3];
   logic signed [31:0]        box_ff   [6];
   logic signed [T_W-1:0]     t1_ff;
   logic signed [T_W-1:0]     tmin_ff;
   logic signed [T_W-1:0]     tmax_ff;
   logic                      found_ff;
   logic [FRAC_W-1:0]         bfrac_ff;
   logic [IDX_W-1:0]          bidx_ff;
   logic signed [31:0]        bbox_ff  [6];
   logic [CNT_W-1:0]          count_ff;
   logic signed [31:0]        point_ff [3];
   logic                      rsp_tvalid_ff;
   logic                      rsp_tuser_ff;
   logic [319:0]              rsp_tdata_ff;

   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [49:0]        prod_rnd;
   logic signed [31:0]        sc_sel;
   logic signed [MUL_W-1:0]   k_sel;
   logic signed [32:0]        dir     [3];
   logic signed [32:0]        dir_sel;
   logic signed [31:0]        st_sel;
   logic signed [31:0]        lo_sel;
   logic signed [31:0]        hi_sel;
   logic signed [33:0]        off_lo;
   logic signed [33:0]        off_hi;
   div_req_type               div_req;
   div_rsp_type               div_rsp;
   logic signed [T_W-1:0]     t_lo;
   logic signed [T_W-1:0]     t_hi;
   logic signed [T_W-1:0]     tmin_nx;
   logic signed [T_W-1:0]     tmax_nx;
   logic                      out_free;
   logic                      accept;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // segment direction per axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dir[i] = 33'(end_ff[i]) - 33'(start_ff[i]);
      end
   end

   // operand selection by step
   always_comb begin
      case (cnt_ff)
         2'd0:    sc_sel = sc_ff[0];
         2'd1:    sc_sel = sc_ff[1];
         2'd2:    sc_sel = sc_ff[2];
         default: sc_sel = '0;
      endcase
      case (cnt_ff)
         2'd0: begin
            case (kind_ff)
               MESH_CAPSULE: k_sel = K_CAP_XZ;
               MESH_RECT:    k_sel = K_RECT_X;
               default:      k_sel = K_BOX_XZ;
            endcase
         end
         2'd1: begin
            case (kind_ff)
               MESH_CAPSULE, MESH_RECT: k_sel = K_TALL_H;
               default:                 k_sel = K_BOX_H;
            endcase
         end
         default: begin
            case (kind_ff)
               MESH_CAPSULE: k_sel = K_CAP_XZ;
               MESH_RECT:    k_sel = K_RECT_Z;
               default:      k_sel = K_BOX_XZ;
            endcase
         end
      endcase
   end

   // multiplier inputs
   always_comb begin
      case (state_ff)
         S_SQ: begin
            mul_a = 33'(sc_sel);
            mul_b = 33'(sc_sel);
         end
         S_HALF: begin
            mul_a = 33'(sc_sel);
            mul_b = k_sel;
         end
         S_POINT: begin
            case (cnt_ff)
               2'd0:    mul_a = dir[0];
               2'd1:    mul_a = dir[1];
               default: mul_a = dir[2];
            endcase
            mul_b = 33'($signed({1'b0, bfrac_ff}));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   nabp_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   assign prod_rnd = round_q16(mul_p);

   // slab operands of the current axis
   always_comb begin
      case (axis_ff)
         2'd0: begin
            dir_sel = dir[0]; st_sel = start_ff[0];
            lo_sel = box_ff[0]; hi_sel = box_ff[3];
         end
         2'd1: begin
            dir_sel = dir[1]; st_sel = start_ff[1];
            lo_sel = box_ff[1]; hi_sel = box_ff[4];
         end
         default: begin
            dir_sel = dir[2]; st_sel = start_ff[2];
            lo_sel = box_ff[2]; hi_sel = box_ff[5];
         end
      endcase
      off_lo = 34'(lo_sel) - 34'(st_sel);
      off_hi = 34'(hi_sel) - 34'(st_sel);
   end

   // divider request: low bound from the axis step, high bound after it
   always_comb begin
      div_req.den = dir_sel;
      if (state_ff == S_DIV_LO) begin
         div_req.num   = NUM_W'({off_hi, 16'b0});
         div_req.start = div_rsp.done;
      end else begin
         div_req.num   = NUM_W'({off_lo, 16'b0});
         div_req.start = (state_ff == S_AXIS) && (dir_sel != '0);
      end
   end

   nabp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // interval clip
   always_comb begin
      t_lo    = (t1_ff <= div_rsp.quo) ? t1_ff : div_rsp.quo;
      t_hi    = (t1_ff <= div_rsp.quo) ? div_rsp.quo : t1_ff;
      tmin_nx = (t_lo > tmin_ff) ? t_lo : tmin_ff;
      tmax_nx = (t_hi < tmax_ff) ? t_hi : tmax_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
         end
      end else if (csr_we) begin
         case (csr_addr)
            CSR_START_X: start_ff[0] <= csr_wdata;
            CSR_START_Y: start_ff[1] <= csr_wdata;
            CSR_START_Z: start_ff[2] <= csr_wdata;
            CSR_END_X:   end_ff[0]   <= csr_wdata;
            CSR_END_Y:   end_ff[1]   <= csr_wdata;
            CSR_END_Z:   end_ff[2]   <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         axis_ff       <= '0;
         found_ff      <= 1'b0;
         bfrac_ff      <= FRAC_ONE;
         bidx_ff       <= '0;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            bbox_ff[i] <= '0;
         end
      end else begin
         // the emit step reloads the output register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_EMIT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < 3; i++) begin
                     pos_ff[i] <= req_tdata[32*i +: 32];
                     sc_ff[i]  <= req_tdata[96 + 32*i +: 32];
                  end
                  kind_ff <= req_tuser[1:0];
                  last_ff <= req_tlast;
                  cnt_ff  <= '0;
                  ssum_ff <= '0;
                  if ((count_ff < CNT_W'(MAX_ITEMS)) && req_tuser[2]) begin
                     state_ff <= S_SQ;
                  end else begin
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_SQ: begin
               if (cnt_ff != 2'd0) begin
                  ssum_ff <= ssum_ff + mul_p[63:0];
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_UNIT;
               end
            end
            S_UNIT: begin
               if (ssum_ff <= SCALE_EPS_Q32) begin
                  for (int i = 0; i < 3; i++) begin
                     sc_ff[i] <= SCALE_UNIT;
                  end
               end
               cnt_ff   <= '0;
               state_ff <= S_HALF;
            end
            S_HALF: begin
               case (cnt_ff)
                  2'd1:    half_ff[0] <= prod_rnd[33:0];
                  2'd2:    half_ff[1] <= prod_rnd[33:0];
                  2'd3:    half_ff[2] <= prod_rnd[33:0];
                  default: ;
               endcase
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_BOX;
               end
            end
            S_BOX: begin
               box_ff[0] <= sat32(36'(pos_ff[0]) - 36'(half_ff[0]));
               box_ff[1] <= pos_ff[1];
               box_ff[2] <= sat32(36'(pos_ff[2]) - 36'(half_ff[2]));
               box_ff[3] <= sat32(36'(pos_ff[0]) + 36'(half_ff[0]));
               box_ff[4] <= sat32(36'(pos_ff[1]) + 36'(half_ff[1]));
               box_ff[5] <= sat32(36'(pos_ff[2]) + 36'(half_ff[2]));
               axis_ff   <= '0;
               tmin_ff   <= '0;
               tmax_ff   <= T_W'(FRAC_ONE);
               state_ff  <= S_AXIS;
            end
            S_AXIS: begin
               if (dir_sel != '0) begin
                  state_ff <= S_DIV_LO;
               end else if (st_sel < lo_sel || st_sel > hi_sel) begin
                  state_ff <= S_NEXT;
               end else if (axis_ff == 2'd2) begin
                  state_ff <= S_BEST;
               end else begin
                  axis_ff <= axis_ff + 2'd1;
               end
            end
            S_DIV_LO: begin
               if (div_rsp.done) begin
                  t1_ff    <= div_rsp.quo;
                  state_ff <= S_DIV_HI;
               end
            end
            S_DIV_HI: begin
               if (div_rsp.done) begin
                  tmin_ff <= tmin_nx;
                  tmax_ff <= tmax_nx;
                  if (tmin_nx > tmax_nx) begin
                     state_ff <= S_NEXT;
                  end else if (axis_ff == 2'd2) begin
                     state_ff <= S_BEST;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= S_AXIS;
                  end
               end
            end
            S_BEST: begin
               if (!found_ff || (tmin_ff[FRAC_W-1:0] < bfrac_ff)) begin
                  found_ff <= 1'b1;
                  bfrac_ff <= tmin_ff[FRAC_W-1:0];
                  bidx_ff  <= count_ff[IDX_W-1:0];
                  for (int i = 0; i < 6; i++) begin
                     bbox_ff[i] <= box_ff[i];
                  end
               end
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
               cnt_ff   <= '0;
               state_ff <= last_ff ? S_POINT : S_IDLE;
            end
            S_POINT: begin
               case (cnt_ff)
                  2'd1: point_ff[0] <= sat32(36'(start_ff[0]) + 36'(prod_rnd));
                  2'd2: point_ff[1] <= sat32(36'(start_ff[1]) + 36'(prod_rnd));
                  2'd3: point_ff[2] <= sat32(36'(start_ff[2]) + 36'(prod_rnd));
                  default: ;
               endcase
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tuser_ff  <= found_ff;
                  if (found_ff) begin
                     rsp_tdata_ff <= {5'b0,
                        bbox_ff[5], bbox_ff[4], bbox_ff[3],
                        bbox_ff[2], bbox_ff[1], bbox_ff[0],
                        point_ff[2], point_ff[1], point_ff[0],
                        bfrac_ff, bidx_ff};
                  end else begin
                     rsp_tdata_ff <= '0;
                  end
                  // start a fresh list
                  found_ff <= 1'b0;
                  bfrac_ff <= FRAC_ONE;
                  bidx_ff  <= '0;
                  count_ff <= '0;
                  for (int i = 0; i < 6; i++) begin
                     bbox_ff[i] <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // checks
`include "nearest_actor_box_pick_assert.svh"

   `NABP_ASSERT_IMP(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "miss item carries data")
   `NABP_ASSERT_IMP(a_frac_range, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[26:10] <= 17'd65536, "hit fraction above one")
   `NABP_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "ready held after accept")
   `NABP_ASSERT_IMP(a_div_owned, clock, reset, div_rsp.done, state_ff == S_DIV_LO || state_ff == S_DIV_HI, "divider done outside slab steps")

endmodule
